// ===== rtl/core/cascaded_biquad_iir_multichannel_core_defines.svh =====
// Assertion macros shared by the checker of the biquad cascade core.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef CASCADED_BIQUAD_IIR_MULTICHANNEL_CORE_DEFINES_SVH
`define CASCADED_BIQUAD_IIR_MULTICHANNEL_CORE_DEFINES_SVH

// same-cycle implication
`define BQD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bqd assertion failed");

// next-cycle implication
`define BQD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bqd assertion failed");

`endif

// ===== rtl/core/bqd_pkg.sv =====
// Package for the biquad cascade core: sizes, step codes, command struct,
// rounding and saturation helpers. No dependencies.
`default_nettype none
package bqd_pkg;

  localparam int CHANNELS   = 4;
  localparam int SECTIONS   = 4;
  localparam int COEF_WORDS = SECTIONS * 6;
  localparam int CH_W       = 2;
  localparam int SEC_W      = 2;
  localparam int ROWS       = CHANNELS * SECTIONS;
  localparam int ROW_W      = CH_W + SEC_W;
  localparam int CIDX_W     = 5;
  localparam int ACC_W      = 40;

  typedef logic [2:0] step_t;
  localparam step_t STEP_B0   = 3'd0;
  localparam step_t STEP_B1   = 3'd1;
  localparam step_t STEP_B2   = 3'd2;
  localparam step_t STEP_A1   = 3'd3;
  localparam step_t STEP_A2   = 3'd4;
  localparam step_t STEP_GAIN = 3'd5;
  localparam step_t STEP_OUT  = 3'd6;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  typedef struct packed {
    logic             load;
    logic             coef_wr;
    logic             run;
    step_t            step;
    logic [SEC_W-1:0] sec;
    logic             emit;
  } dp_cmd_t;

  // Q3.28 x Q16.15 product rounded to Q.15 (floor after adding half)
  function automatic logic signed [35:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd134217728;
    return t[63:28];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [17:0] q;
    logic signed [15:0] r;
    t = 33'(v) + 33'sd16384;
    q = t[32:15];
    if (q > 18'sd32767) r = 16'sh7fff;
    else if (q < -18'sd32768) r = 16'sh8000;
    else r = q[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bqd_ctrl.sv =====
// Sequencer of the biquad cascade: handshakes, section and step counters.
// Depends on bqd_pkg.
`default_nettype none
module bqd_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   in_cmd,
  input  wire [bqd_pkg::CH_W-1:0] in_channel,
  output logic                  out_valid,
  input  wire                   out_ready,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [2:0]             cfg_active_sections,
  output bqd_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  bqd_pkg::step_t            step_r, step_nxt;
  logic [bqd_pkg::SEC_W-1:0] sec_r, sec_nxt, last_sec;
  logic [2:0]                nsec_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      acc, ch_ok, emit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign acc       = in_valid && in_ready;
  assign ch_ok     = {1'b0, in_channel} < (bqd_pkg::CH_W + 1)'(bqd_pkg::CHANNELS);
  assign emit      = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // zero acts as one, oversize clamps to the last section
  always_comb begin
    if (nsec_r == 3'd0) last_sec = '0;
    else if (nsec_r > 3'(bqd_pkg::SECTIONS)) last_sec = bqd_pkg::SEC_W'(bqd_pkg::SECTIONS - 1);
    else last_sec = bqd_pkg::SEC_W'(nsec_r - 3'd1);
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    sec_nxt       = sec_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc && in_cmd == bqd_pkg::CMD_FILTER && ch_ok) begin
          state_nxt = S_RUN;
          step_nxt  = bqd_pkg::STEP_B0;
          sec_nxt   = '0;
        end
      end
      S_RUN: begin
        if (step_r == bqd_pkg::STEP_OUT) begin
          step_nxt = bqd_pkg::STEP_B0;
          if (sec_r == last_sec) state_nxt = S_FIN;
          else sec_nxt = sec_r + 1'b1;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_FIN: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= bqd_pkg::STEP_B0;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
      nsec_r      <= 3'd1;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) nsec_r <= cfg_active_sections;
    end
  end

  always_comb begin
    cmd.load    = acc && in_cmd == bqd_pkg::CMD_FILTER && ch_ok;
    cmd.coef_wr = acc && in_cmd == bqd_pkg::CMD_COEF;
    cmd.run     = (state_r == S_RUN);
    cmd.step    = step_r;
    cmd.sec     = sec_r;
    cmd.emit    = emit;
  end

endmodule
`default_nettype wire

// ===== rtl/core/bqd_dp.sv =====
// Datapath of the biquad cascade: coefficient and history stores, shared
// multiplier, accumulators, output word register. Depends on bqd_pkg.
`default_nettype none
module bqd_dp (
  input  wire                        clk,
  input  wire                        rst_n,
  input  bqd_pkg::dp_cmd_t           cmd,
  input  wire [bqd_pkg::CH_W-1:0]    in_channel,
  input  wire signed [15:0]          in_sample_in,
  input  wire [bqd_pkg::CIDX_W-1:0]  in_coef_index,
  input  wire signed [31:0]          in_coef_value,
  output logic [bqd_pkg::CH_W-1:0]   out_channel,
  output logic signed [15:0]         out_filtered
);

  logic signed [31:0] coef_r [bqd_pkg::COEF_WORDS];
  logic signed [31:0] xh1_r [bqd_pkg::ROWS];
  logic signed [31:0] xh2_r [bqd_pkg::ROWS];
  logic signed [31:0] yh1_r [bqd_pkg::ROWS];
  logic signed [31:0] yh2_r [bqd_pkg::ROWS];

  logic [bqd_pkg::CH_W-1:0]          ch_r, och_r;
  logic signed [31:0]                x_r;
  logic signed [63:0]                prod_r;
  logic signed [bqd_pkg::ACC_W-1:0]  ff_r, fb_r;
  logic signed [15:0]                filt_r;

  logic [bqd_pkg::ROW_W-1:0]         row;
  logic [bqd_pkg::CIDX_W-1:0]        cidx;
  logic signed [31:0]                csel, osel, y32;
  logic signed [35:0]                qp;
  logic signed [bqd_pkg::ACC_W-1:0]  qpw, yw;

  assign row  = {ch_r, cmd.sec};
  assign cidx = bqd_pkg::CIDX_W'(cmd.sec) * bqd_pkg::CIDX_W'(6) + bqd_pkg::CIDX_W'(cmd.step);
  // the output step has no coefficient of its own
  assign csel = (cmd.step == bqd_pkg::STEP_OUT) ? '0 : coef_r[cidx];
  assign qp   = bqd_pkg::qround(prod_r);
  assign qpw  = bqd_pkg::ACC_W'(qp);
  assign yw   = qpw - fb_r;
  assign y32  = bqd_pkg::sat32(yw);

  always_comb begin
    unique case (cmd.step)
      bqd_pkg::STEP_B0:   osel = x_r;
      bqd_pkg::STEP_B1:   osel = xh1_r[row];
      bqd_pkg::STEP_B2:   osel = xh2_r[row];
      bqd_pkg::STEP_A1:   osel = yh1_r[row];
      bqd_pkg::STEP_A2:   osel = yh2_r[row];
      bqd_pkg::STEP_GAIN: osel = bqd_pkg::sat32(ff_r);
      default:            osel = '0;
    endcase
  end

  // product of step k is folded in during step k+1
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r <= in_channel;
      x_r  <= 32'(in_sample_in) <<< 15;
    end
    if (cmd.run) begin
      prod_r <= csel * osel;
      unique case (cmd.step)
        bqd_pkg::STEP_B0: begin
          ff_r <= '0;
          fb_r <= '0;
        end
        bqd_pkg::STEP_B1, bqd_pkg::STEP_B2, bqd_pkg::STEP_A1: ff_r <= ff_r + qpw;
        bqd_pkg::STEP_A2, bqd_pkg::STEP_GAIN:                 fb_r <= fb_r + qpw;
        bqd_pkg::STEP_OUT:                                    x_r  <= y32;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      och_r  <= ch_r;
      filt_r <= bqd_pkg::sat16(x_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bqd_pkg::COEF_WORDS; i++) coef_r[i] <= '0;
    end else if (cmd.coef_wr && in_coef_index < bqd_pkg::CIDX_W'(bqd_pkg::COEF_WORDS)) begin
      coef_r[in_coef_index] <= in_coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bqd_pkg::ROWS; i++) begin
        xh1_r[i] <= '0;
        xh2_r[i] <= '0;
        yh1_r[i] <= '0;
        yh2_r[i] <= '0;
      end
    end else if (cmd.run && cmd.step == bqd_pkg::STEP_OUT) begin
      xh2_r[row] <= xh1_r[row];
      xh1_r[row] <= x_r;
      yh2_r[row] <= yh1_r[row];
      yh1_r[row] <= y32;
    end
  end

  assign out_channel  = och_r;
  assign out_filtered = filt_r;

endmodule
`default_nettype wire

// ===== rtl/core/cascaded_biquad_iir_multichannel_core.sv =====
// Top level of the multichannel direct-form-I biquad cascade.
// Depends on bqd_pkg, bqd_ctrl and bqd_dp.
`default_nettype none
// A word on the input port either filters one sample (cmd 0) or writes one
// Q3.28 coefficient word (cmd 1, index section*6 + k: b0 b1 b2 a1 a2 gain).
// A sample word runs through the first active_sections sections of its
// channel (in effect 1 to 4) on one shared 32x32 multiplier, with six
// products plus the history update per section. The result becomes
// pending, and the input ready again, in the same cycle. The input is
// ready only while the sequencer is idle; a finished word waits in the
// output register, so the next word may be accepted before it is taken.
// Coefficient words are written on acceptance and give no result.
// Histories and coefficients clear to zero at reset. Write cfg only
// while idle.
module cascaded_biquad_iir_multichannel_core (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        in_cmd,
  input  wire [bqd_pkg::CH_W-1:0]    in_channel,
  input  wire signed [15:0]          in_sample_in,
  input  wire [bqd_pkg::CIDX_W-1:0]  in_coef_index,
  input  wire signed [31:0]          in_coef_value,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [bqd_pkg::CH_W-1:0]   out_channel,
  output logic signed [15:0]         out_filtered,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [2:0]                  cfg_active_sections
);

  bqd_pkg::dp_cmd_t cmd;

  // sequencer: handshakes, section/step counters, section count register
  bqd_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_channel          (in_channel),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_active_sections (cfg_active_sections),
    .cmd                 (cmd)
  );

  // arithmetic and stores
  bqd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_channel    (in_channel),
    .in_sample_in  (in_sample_in),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .out_channel   (out_channel),
    .out_filtered  (out_filtered)
  );

endmodule
`default_nettype wire

// ===== rtl/core/bqd_checker.sv =====
// Port-level checker for the biquad cascade core, bound to the top level.
// Depends on bqd_pkg and the core's defines header.
`default_nettype none
`include "cascaded_biquad_iir_multichannel_core_defines.svh"
module bqd_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       in_valid,
  input wire                       in_ready,
  input wire                       in_cmd,
  input wire                       out_valid,
  input wire                       out_ready,
  input wire [bqd_pkg::CH_W-1:0]   out_channel,
  input wire [15:0]                out_filtered
);

  `BQD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_channel) && $stable(out_filtered))
  `BQD_ASSERT_NXT(a_busy_after_sample, in_valid && in_ready && in_cmd == bqd_pkg::CMD_FILTER, !in_ready)
  `BQD_ASSERT_NXT(a_coef_no_word, in_valid && in_ready && in_cmd == bqd_pkg::CMD_COEF && !out_valid, !out_valid)
  `BQD_ASSERT_IMP(a_word_from_busy, $rose(out_valid), $past(!in_ready))

endmodule

bind cascaded_biquad_iir_multichannel_core bqd_checker u_bqd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_cmd       (in_cmd),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_channel  (out_channel),
  .out_filtered (out_filtered)
);
`default_nettype wire
